[hw/rtl/mf2d_pkg.sv]
// Package for the 2D median filter: shared constants, types and state codes.
// Used by the top level, the interfaces, the rank unit and the test bench; depends on nothing.
`timescale 1ns / 1ps
package mf2d_pkg;
	localparam int PIX_W = 16;
	localparam int COL_W = 10;
	localparam int ROW_W = 12;
	localparam int CFG_W = 13;
	localparam int IDX_W = 2;

	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_HALFX  = 2'd2;
	localparam logic [IDX_W-1:0] REG_HALFY  = 2'd3;

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_CENTRE = 8'b0000_0100,
		ST_GATHER = 8'b0000_1000,
		ST_GLAST  = 8'b0001_0000,
		ST_RANK   = 8'b0010_0000,
		ST_PICK   = 8'b0100_0000,
		ST_OUT    = 8'b1000_0000
	} state_t;
endpackage

[hw/rtl/mf2d_if.sv]
// Valid/ready channel interfaces for the input and result items.
// Depends on mf2d_pkg.
`timescale 1ns / 1ps
interface mf2d_in_if import mf2d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              func;
	logic signed [15:0] pixel_value;
	modport source (output valid, func, pixel_value, input ready);
	modport sink (input valid, func, pixel_value, output ready);
endinterface

interface mf2d_out_if import mf2d_pkg::*; ();
	logic               valid;
	logic               ready;
	logic signed [15:0] filtered_value;
	logic [9:0]         out_col;
	logic [11:0]        out_row;
	logic               last_of_frame;
	modport source (output valid, filtered_value, out_col, out_row, last_of_frame,
		input ready);
	modport sink (input valid, filtered_value, out_col, out_row, last_of_frame,
		output ready);
endinterface

[hw/rtl/median_filter_2d.sv]
// Top level of the streaming 2D median filter with a line store and a shared rank unit.
// Depends on mf2d_pkg, mf2d_if, mf2d_ram and mf2d_rank.
// One item at a time: no new item is taken until the previous one has finished.
// Items without a result go back to idle after the readiness check.
// Ranking compares one pair a cycle.
// Reset is asynchronous and active low; it restores the register defaults and frame start.
`timescale 1ns / 1ps
module median_filter_2d import mf2d_pkg::*; #(
	parameter int MAX_HALF  = 3,
	parameter int MAX_WIDTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	mf2d_in_if.sink          in_ch,
	mf2d_out_if.source       out_ch
);
	localparam int RING   = 2 ** $clog2(2 * MAX_HALF + 2);
	localparam int RING_W = $clog2(RING);
	localparam int MCOL_W = $clog2(MAX_WIDTH);
	localparam int CW     = (MCOL_W > COL_W) ? MCOL_W : COL_W;
	localparam int LS_DEPTH = RING * MAX_WIDTH;
	localparam int LS_AW  = $clog2(LS_DEPTH);
	localparam int WMAX   = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
	localparam int WA_W   = $clog2(WMAX);
	localparam int HW     = $clog2(MAX_HALF + 1);
	localparam int MAX_HEIGHT = 4096;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [1:0]  halfx_q, halfy_q;
	logic [ROW_W-1:0] in_row_q, emit_row_q;
	logic [CW-1:0]    in_col_q, emit_col_q;
	logic        full_q;
	state_t      state_q;

	logic [12:0] w_eff, h_eff;
	logic [HW-1:0] hx, hy;
	always_comb begin
		w_eff = (width_q == 11'd0) ? 13'd1 : {2'b0, width_q};
		if (w_eff > 13'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
		h_eff = (height_q == 13'd0) ? 13'd1 : height_q;
		if (h_eff > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
		hx = (32'(halfx_q) > MAX_HALF) ? HW'(MAX_HALF) : HW'(halfx_q);
		hy = (32'(halfy_q) > MAX_HALF) ? HW'(MAX_HALF) : HW'(halfy_q);
	end

	// Readiness check: compare positions instead of products.
	logic [12:0] rr, cc;
	logic        avail;
	always_comb begin
		rr = 13'(emit_row_q) + 13'(hy);
		cc = 13'(emit_col_q) + 13'(hx);
		if (rr > h_eff - 13'd1) rr = h_eff - 13'd1;
		if (cc > w_eff - 13'd1) cc = w_eff - 13'd1;
		avail = full_q || (13'(in_row_q) > rr) ||
			((13'(in_row_q) == rr) && (13'(in_col_q) > cc));
	end

	// Line store.
	logic             ls_we;
	logic [LS_AW-1:0] ls_waddr, ls_raddr;
	logic [PIX_W-1:0] ls_rdata;
	logic [ROW_W-1:0] rd_row;
	logic [MCOL_W-1:0] rd_col;
	logic [ROW_W-1:0] in_row_eff;
	logic [CW-1:0]    in_col_eff;
	logic [RING_W-1:0] wr_ring, rd_ring;
	assign in_row_eff = full_q ? '0 : in_row_q;
	assign in_col_eff = full_q ? '0 : in_col_q;
	assign wr_ring = RING_W'(in_row_eff % RING);
	assign rd_ring = RING_W'(rd_row % RING);
	assign ls_waddr = LS_AW'(wr_ring * MAX_WIDTH + MCOL_W'(in_col_eff));
	assign ls_raddr = LS_AW'(rd_ring * MAX_WIDTH + rd_col);

	mf2d_ram #(.WIDTH(PIX_W), .DEPTH(LS_DEPTH)) u_line (
		.clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(in_ch.pixel_value),
		.raddr(ls_raddr), .rdata(ls_rdata));

	// Window store.
	logic            win_we;
	logic [WA_W-1:0] win_waddr, win_raddr;
	logic [PIX_W-1:0] win_wdata, win_rdata;
	mf2d_ram #(.WIDTH(PIX_W), .DEPTH(WMAX)) u_win (
		.clk(clk), .we(win_we), .waddr(win_waddr), .wdata(win_wdata),
		.raddr(win_raddr), .rdata(win_rdata));

	// Sequencer counters.
	logic signed [HW+1:0] dy_q, dx_q;
	logic                 pend_q, inside_q;
	logic [PIX_W-1:0]     centre_q, cand_q, med_q;
	logic [WA_W:0]        n_q, i_q, j_q, n_tot;
	logic                 rk_clear, rk_en;
	logic [6:0]           less_cnt, eq_cnt;
	logic                 found;
	logic                 last_q;

	assign n_tot = (WA_W+1)'((2 * hx + 1) * (2 * hy + 1));

	mf2d_rank u_rank (
		.clk(clk), .clear(rk_clear), .en(rk_en), .cand(cand_q), .sample(win_rdata),
		.less_cnt(less_cnt), .eq_cnt(eq_cnt));

	logic signed [ROW_W+1:0] sr;
	logic signed [CW+1:0]    sc;
	logic                    s_in;
	always_comb begin
		sr = $signed({2'b0, emit_row_q}) + (ROW_W+2)'(dy_q);
		sc = $signed({2'b0, emit_col_q}) + (CW+2)'(dx_q);
		s_in = (sr >= 0) && (sr < $signed({1'b0, h_eff})) &&
			(sc >= 0) && (sc < $signed({1'b0, w_eff}));
		rd_row = emit_row_q;
		rd_col = MCOL_W'(emit_col_q);
		if (state_q == ST_GATHER) begin
			rd_row = ROW_W'(sr);
			rd_col = MCOL_W'(sc);
		end
	end

	logic [6:0] mid;
	assign mid = 7'(n_tot >> 1);
	assign found = (less_cnt <= mid) && (mid < less_cnt + eq_cnt);

	assign in_ch.ready = (state_q == ST_IDLE) && !cfg_we;
	assign ls_we = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_PIXEL);
	assign win_we = pend_q;
	assign win_wdata = inside_q ? ls_rdata : centre_q;
	// The candidate for the next rank pass is read in the cycle before that pass starts.
	assign win_raddr = (state_q == ST_RANK) ? WA_W'(j_q) :
		(state_q == ST_PICK) ? WA_W'(i_q + 1'b1) : '0;
	assign rk_clear = (state_q == ST_PICK) || (state_q == ST_GLAST);
	assign rk_en = (state_q == ST_RANK) && (j_q != '0);

	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.filtered_value = med_q;
	assign out_ch.out_col = COL_W'(emit_col_q);
	assign out_ch.out_row = emit_row_q;
	assign out_ch.last_of_frame = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd256; height_q <= 13'd256; halfx_q <= 2'd1; halfy_q <= 2'd1;
			in_row_q <= '0; in_col_q <= '0; emit_row_q <= '0; emit_col_q <= '0;
			full_q <= 1'b0; state_q <= ST_IDLE; pend_q <= 1'b0; inside_q <= 1'b0;
			dy_q <= '0; dx_q <= '0; n_q <= '0; i_q <= '0; j_q <= '0; last_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[10:0];
				REG_HEIGHT: height_q <= cfg_data;
				REG_HALFX:  halfx_q  <= cfg_data[1:0];
				REG_HALFY:  halfy_q  <= cfg_data[1:0];
				default: ;
			endcase
			in_row_q <= '0; in_col_q <= '0; emit_row_q <= '0; emit_col_q <= '0;
			full_q <= 1'b0; state_q <= ST_IDLE; pend_q <= 1'b0;
		end else begin
			pend_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						if (in_ch.func == FUNC_PIXEL) begin
							if (full_q) begin
								emit_row_q <= '0; emit_col_q <= '0;
							end
							full_q <= 1'b0;
							if (13'(in_col_eff) + 13'd1 >= w_eff) begin
								in_col_q <= '0;
								if (13'(in_row_eff) + 13'd1 >= h_eff) begin
									in_row_q <= '0; full_q <= 1'b1;
								end else begin
									in_row_q <= in_row_eff + 1'b1;
								end
							end else begin
								in_col_q <= in_col_eff + 1'b1;
								in_row_q <= in_row_eff;
							end
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= avail ? ST_CENTRE : ST_IDLE;
				ST_CENTRE: begin
					dy_q <= -(HW+2)'(hy); dx_q <= -(HW+2)'(hx); n_q <= '0;
					state_q <= ST_GATHER;
				end
				ST_GATHER: begin
					if (dy_q == -(HW+2)'(hy) && dx_q == -(HW+2)'(hx))
						centre_q <= ls_rdata;
					pend_q <= 1'b1; inside_q <= s_in;
					if (dx_q == (HW+2)'(hx)) begin
						dx_q <= -(HW+2)'(hx);
						dy_q <= dy_q + 1'b1;
						if (dy_q == (HW+2)'(hy)) state_q <= ST_GLAST;
					end else begin
						dx_q <= dx_q + 1'b1;
					end
				end
				ST_GLAST: begin
					i_q <= '0; j_q <= '0; state_q <= ST_RANK;
				end
				ST_RANK: begin
					if (j_q == '0) cand_q <= win_rdata;
					if (j_q == n_tot) state_q <= ST_PICK;
					else j_q <= j_q + 1'b1;
				end
				ST_PICK: begin
					if (found || i_q + 1'b1 == n_tot) begin
						med_q <= found ? cand_q : centre_q;
						last_q <= (13'(emit_row_q) == h_eff - 13'd1) &&
							(13'(emit_col_q) == w_eff - 13'd1);
						state_q <= ST_OUT;
					end else begin
						i_q <= i_q + 1'b1; j_q <= '0; state_q <= ST_RANK;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							in_row_q <= '0; in_col_q <= '0; emit_row_q <= '0;
							emit_col_q <= '0; full_q <= 1'b0;
						end else if (13'(emit_col_q) + 13'd1 >= w_eff) begin
							emit_col_q <= '0; emit_row_q <= emit_row_q + 1'b1;
						end else begin
							emit_col_q <= emit_col_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Window write address trails the gather read: each sample is written the cycle after it is read.
	always_ff @(posedge clk) begin
		if (state_q == ST_CENTRE) win_waddr <= '0;
		else if (pend_q) win_waddr <= win_waddr + 1'b1;
	end
endmodule

[hw/rtl/mf2d_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mf2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hw/rtl/mf2d_rank.sv]
// Shared rank unit: compares one window sample against a candidate each cycle that en is high.
// Depends on mf2d_pkg.
`timescale 1ns / 1ps
module mf2d_rank import mf2d_pkg::*; (
	input  logic                    clk,
	input  logic                    clear,
	input  logic                    en,
	input  logic signed [PIX_W-1:0] cand,
	input  logic signed [PIX_W-1:0] sample,
	output logic [6:0]              less_cnt,
	output logic [6:0]              eq_cnt
);
	always_ff @(posedge clk) begin
		if (clear) begin
			less_cnt <= '0;
			eq_cnt   <= '0;
		end else if (en) begin
			if (sample < cand) begin
				less_cnt <= less_cnt + 7'd1;
			end else if (sample == cand) begin
				eq_cnt <= eq_cnt + 7'd1;
			end
		end
	end
endmodule

[hw/rtl/mf2d_checker.sv]
// Port-level assertions for the median filter, bound to the top level.
// Depends on median_filter_2d.
`timescale 1ns / 1ps
module mf2d_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] filtered_value
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_value))
		else $error("Result changed while stalled.");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("Input taken while a result waits.");
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Second item taken before the first finished.");
endmodule

bind median_filter_2d mf2d_props u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.filtered_value(out_ch.filtered_value));

[test/mf2d_checker.sv]
// Checker for the 2D median filter: watches both channels, predicts each result
// from its own frame model and compares field by field. Depends on mf2d_pkg and mf2d_if.
`timescale 1ns / 1ps
module mf2d_checker import mf2d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	mf2d_in_if.sink          in_mon,
	mf2d_out_if.sink         out_mon,
	output int               fail_count,
	output int               pending_count
);
	localparam int HALF_LIM = 3;
	localparam int WIDTH_LIM = 1024;
	localparam int RING = 2 * HALF_LIM + 2;

	typedef struct packed {
		logic signed [15:0] value;
		logic [9:0]         col;
		logic [11:0]        row;
		logic               last;
	} pix_out_t;

	logic signed [15:0] rows_seen [RING*WIDTH_LIM];
	int unsigned width_reg, height_reg, hx_reg, hy_reg;
	int unsigned next_in_col, next_in_row, next_out_col, next_out_row;
	bit frame_done;
	pix_out_t expected_pixels[$];

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		return (width_reg > WIDTH_LIM) ? WIDTH_LIM : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		return (height_reg > 4096) ? 4096 : height_reg;
	endfunction

	function automatic logic signed [15:0] stored(int unsigned r, int unsigned c);
		return rows_seen[(r % RING) * WIDTH_LIM + (c % WIDTH_LIM)];
	endfunction

	task automatic new_frame();
		next_in_col = 0;
		next_in_row = 0;
		next_out_col = 0;
		next_out_row = 0;
		frame_done = 0;
	endtask

	task automatic predict_median();
		int unsigned w, h, hx, hy, got, rr, cc, cnt, less, same;
		int r, c;
		logic signed [15:0] win [49];
		logic signed [15:0] centre, med, smp;
		pix_out_t p;
		w = eff_width();
		h = eff_height();
		hx = (hx_reg > HALF_LIM) ? HALF_LIM : hx_reg;
		hy = (hy_reg > HALF_LIM) ? HALF_LIM : hy_reg;
		got = frame_done ? w * h : next_in_row * w + next_in_col;
		rr = next_out_row + hy;
		cc = next_out_col + hx;
		if (rr > h - 1) rr = h - 1;
		if (cc > w - 1) cc = w - 1;
		if (got <= rr * w + cc) return;
		centre = stored(next_out_row, next_out_col);
		cnt = 0;
		for (int dy = -int'(hy); dy <= int'(hy); dy++) begin
			for (int dx = -int'(hx); dx <= int'(hx); dx++) begin
				r = int'(next_out_row) + dy;
				c = int'(next_out_col) + dx;
				smp = centre;
				if (r >= 0 && r < int'(h) && c >= 0 && c < int'(w))
					smp = stored(r, c);
				win[cnt] = smp;
				cnt++;
			end
		end
		med = centre;
		for (int i = 0; i < cnt; i++) begin
			less = 0;
			same = 0;
			for (int j = 0; j < cnt; j++) begin
				if (win[j] < win[i]) less++;
				else if (win[j] == win[i]) same++;
			end
			if (less <= cnt / 2 && cnt / 2 < less + same) begin
				med = win[i];
				break;
			end
		end
		p.value = med;
		p.col = next_out_col[9:0];
		p.row = next_out_row[11:0];
		p.last = (next_out_row == h - 1) && (next_out_col == w - 1);
		expected_pixels.push_back(p);
		if (p.last) begin
			new_frame();
		end else begin
			next_out_col++;
			if (next_out_col >= w) begin
				next_out_col = 0;
				next_out_row++;
			end
		end
	endtask

	task automatic accept_item(logic fn, logic signed [15:0] px);
		if (fn == FUNC_PIXEL) begin
			if (frame_done) new_frame();
			rows_seen[(next_in_row % RING) * WIDTH_LIM + next_in_col] = px;
			next_in_col++;
			if (next_in_col >= eff_width()) begin
				next_in_col = 0;
				next_in_row++;
				if (next_in_row >= eff_height()) begin
					next_in_row = 0;
					frame_done = 1;
				end
			end
		end
		predict_median();
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_out_t exp_p;
		if (!arst_n) begin
			width_reg = 256;
			height_reg = 256;
			hx_reg = 1;
			hy_reg = 1;
			new_frame();
			expected_pixels.delete();
			fail_count = 0;
			pending_count = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (expected_pixels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: value %0d col %0d row %0d last %0d",
							out_mon.filtered_value, out_mon.out_col, out_mon.out_row,
							out_mon.last_of_frame);
				end else begin
					exp_p = expected_pixels.pop_front();
					if (exp_p.value !== out_mon.filtered_value || exp_p.col !== out_mon.out_col
						|| exp_p.row !== out_mon.out_row || exp_p.last !== out_mon.last_of_frame) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
								exp_p.value, exp_p.col, exp_p.row, exp_p.last,
								out_mon.filtered_value, out_mon.out_col, out_mon.out_row,
								out_mon.last_of_frame);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: width_reg = cfg_data[10:0];
					REG_HEIGHT: height_reg = cfg_data[12:0];
					REG_HALFX: hx_reg = cfg_data[1:0];
					REG_HALFY: hy_reg = cfg_data[1:0];
					default: ;
				endcase
				new_frame();
			end
			if (in_mon.valid && in_mon.ready)
				accept_item(in_mon.func, in_mon.pixel_value);
			pending_count = expected_pixels.size();
		end
	end
endmodule

[test/tb_median_filter_2d.sv]
// Testbench top for the 2D median filter: drives frames, drain items and register
// settings, and gives the verdict. Depends on mf2d_pkg, mf2d_if and mf2d_checker.
`timescale 1ns / 1ps
module tb_median_filter_2d import mf2d_pkg::*; ();
	localparam int STALL_LIMIT = 40000;
	localparam int ITEM_BUDGET = 750;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = REG_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	bit steady = 0;
	int fail_count, pending_count, idle_cycles, sent;
	int frame_w, frame_h;

	mf2d_in_if in_ch();
	mf2d_out_if out_ch();

	median_filter_2d dut (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source));

	mf2d_checker checker_i (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .in_mon(in_ch.sink),
		.out_mon(out_ch.sink), .fail_count(fail_count), .pending_count(pending_count));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		in_ch.valid = 0;
		in_ch.func = FUNC_PIXEL;
		in_ch.pixel_value = '0;
		out_ch.ready = 0;
	end

	always @(negedge clk)
		out_ch.ready <= steady || ($urandom_range(99) >= 22);

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("median_filter_2d test failed");
			$finish;
		end
	end

	task automatic send_item(logic fn, logic signed [15:0] px);
		while (!steady && $urandom_range(99) < 22) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.func <= fn;
		in_ch.pixel_value <= px;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle();
		in_ch.valid <= 0;
		while (pending_count != 0) @(negedge clk);
		repeat (3000) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic set_shape(int w, int h, int hx, int hy);
		settle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_HALFX, hx);
		write_reg(REG_HALFY, hy);
		frame_w = (w == 0) ? 1 : w;
		frame_h = (h == 0) ? 1 : h;
	endtask

	function automatic logic signed [15:0] rand_pixel();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_frame(int drains);
		for (int i = 0; i < frame_w * frame_h && sent < ITEM_BUDGET; i++) begin
			if ($urandom_range(19) == 0) send_item(FUNC_DRAIN, 16'($urandom));
			send_item(FUNC_PIXEL, rand_pixel());
		end
		repeat (drains) send_item(FUNC_DRAIN, 16'($urandom));
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// Directed: extreme values, early drain, partial frame cut short.
		set_shape(3, 3, 1, 1);
		send_item(FUNC_DRAIN, 16'sh7fff);
		send_item(FUNC_PIXEL, 16'sh7fff);
		send_item(FUNC_PIXEL, 16'sh8000);
		send_item(FUNC_PIXEL, 16'sh0000);
		send_item(FUNC_PIXEL, -16'sd1);
		send_item(FUNC_PIXEL, 16'sh7fff);
		send_item(FUNC_PIXEL, 16'sh8000);
		send_item(FUNC_PIXEL, 16'sh5555);
		send_item(FUNC_PIXEL, 16'shaaaa);
		send_item(FUNC_PIXEL, 16'sh0001);
		send_item(FUNC_DRAIN, 16'sh0000);
		send_item(FUNC_PIXEL, 16'sh1234);
		set_shape(0, 0, 0, 0);
		send_item(FUNC_PIXEL, 16'sh8000);
		send_item(FUNC_DRAIN, 16'sh0000);
		set_shape(1, 5, 3, 3);
		run_frame(3);
		set_shape(5, 1, 3, 0);
		run_frame(1);
		// Random frames over a range of shapes, with wide and tall extremes.
		while (sent < ITEM_BUDGET) begin
			if ($urandom_range(7) == 0) steady = !steady;
			case ($urandom_range(9))
				0: set_shape(1024, 1, $urandom_range(3), $urandom_range(3));
				1: set_shape(1, 30, $urandom_range(3), $urandom_range(3));
				2: set_shape(1100, 1, 0, 0);
				default: set_shape($urandom_range(1, 9), $urandom_range(1, 9),
					$urandom_range(3), $urandom_range(3));
			endcase
			run_frame($urandom_range(0, 30));
			if ($urandom_range(3) == 0) begin
				settle();
				write_reg(REG_HALFY, $urandom_range(3));
			end
		end
		steady = 0;
		settle();
		if (fail_count == 0)
			$display("median_filter_2d test passed");
		else
			$display("median_filter_2d test failed");
		$finish;
	end
endmodule
